/* rtl/cbm_pkg.sv */
// cbm_pkg: shared types and constants for the cartridge bank mapper with scanline irq
// no dependencies; used by cbm_core and cartridge_bank_mapper_irq_top
package cbm_pkg;

  localparam int unsigned ChrSlots  = 8;
  localparam int unsigned SlotW     = $clog2(ChrSlots);
  localparam int unsigned BankW     = 8;
  localparam int unsigned AddrW     = 16;
  localparam int unsigned CountW    = 9;

  localparam logic [3:0] PagePrgSel = 4'h8;
  localparam logic [3:0] PageCtrl   = 4'h9;
  localparam logic [3:0] PagePrgMid = 4'hA;
  localparam logic [3:0] PageChrLo  = 4'hB;
  localparam logic [3:0] PageChrHi  = 4'hE;
  localparam logic [3:0] PageIrq    = 4'hF;

  localparam logic [BankW-1:0]  PrgMidReset = 8'd1;
  localparam logic [CountW-1:0] CountReset  = 9'd16;
  localparam logic [BankW-1:0]  FireNormal  = 8'hFF;
  localparam logic [BankW-1:0]  FirePatch   = 8'h00;

  localparam logic [0:0] RegPatchMode = 1'b0;
  localparam logic [0:0] RegBankCount = 1'b1;

  typedef enum logic [0:0] {
    OpWrite = 1'b0,
    OpTick  = 1'b1
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [AddrW-1:0] address;
    logic [BankW-1:0] write_data;
  } item_t;

  typedef struct packed {
    logic             irq_pulse;
    logic [BankW-1:0] chr_bank;
    logic [SlotW-1:0] chr_slot;
    logic             chr_update;
    logic [1:0]       mirror_mode;
    logic [BankW-1:0] prg_bank_hi;
    logic [BankW-1:0] prg_bank_mid;
    logic [BankW-1:0] prg_bank_lo;
  } result_t;

  typedef struct packed {
    logic              wr;
    logic [0:0]        idx;
    logic [CountW-1:0] data;
  } cfg_wr_t;

endpackage

/* rtl/cbm_core.sv */
// cbm_core: mapper state registers and the single-pass update for one request
// depends on cbm_pkg
module cbm_core import cbm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  item_t             item_i,
  input  cfg_wr_t           cfg_i,
  output result_t           result_o,
  output logic              patch_mode_o,
  output logic [CountW-1:0] bank_count_o
);

  logic [BankW-1:0]  chr_q [ChrSlots];
  logic [BankW-1:0]  prg_lo_q, prg_lo_d;
  logic [BankW-1:0]  prg_mid_q, prg_mid_d;
  logic [BankW-1:0]  prg_hi_q, prg_hi_d;
  logic              swap_q, swap_d;
  logic [1:0]        mirror_q, mirror_d;
  logic [BankW-1:0]  latch_q, latch_d;
  logic [BankW-1:0]  count_q, count_d;
  logic [1:0]        enable_q, enable_d;
  logic              patch_q;
  logic [CountW-1:0] bank_count_q;

  logic [3:0]        page;
  logic [3:0]        low;
  logic              grp_hit;
  logic [1:0]        grp;
  logic              chr_wr;
  logic [SlotW-1:0]  slot;
  logic [BankW-1:0]  chr_val;
  logic              pulse;
  logic [BankW-1:0]  fire;
  logic [3:0]        page_off;

  assign page     = item_i.address[15:12];
  assign low      = item_i.address[3:0];
  assign page_off = page - PageChrLo;
  assign slot     = {page_off[1:0], grp[0]};
  assign fire     = patch_q ? FirePatch : FireNormal;

  always_comb begin
    grp_hit = 1'b1;
    grp     = 2'd0;
    unique case (low)
      4'h0:       grp = 2'd0;
      4'h1, 4'h4: grp = 2'd1;
      4'h2, 4'h8: grp = 2'd2;
      4'h3, 4'hC: grp = 2'd3;
      default:    grp_hit = 1'b0;
    endcase
  end

  always_comb begin
    prg_lo_d  = prg_lo_q;
    prg_mid_d = prg_mid_q;
    prg_hi_d  = prg_hi_q;
    swap_d    = swap_q;
    mirror_d  = mirror_q;
    latch_d   = latch_q;
    count_d   = count_q;
    enable_d  = enable_q;
    chr_wr    = 1'b0;
    chr_val   = chr_q[slot];
    pulse     = 1'b0;
    if (item_i.op == OpTick) begin
      if (enable_q[1]) begin
        if (count_q == fire) begin
          count_d = latch_q;
          pulse   = 1'b1;
        end else begin
          count_d = count_q + 8'd1;
        end
      end
    end else begin
      priority if (page == PagePrgSel) begin
        if (swap_q) prg_hi_d = item_i.write_data;
        else prg_lo_d = item_i.write_data;
      end else if (page == PagePrgMid) begin
        prg_mid_d = item_i.write_data;
      end else if (page == PageCtrl) begin
        if (grp_hit && grp == 2'd0) begin
          mirror_d = item_i.write_data[1:0];
        end else if (grp_hit && grp == 2'd1) begin
          swap_d = item_i.write_data[1];
          if (item_i.write_data[1] != swap_q) begin
            prg_lo_d = prg_hi_q;
            prg_hi_d = prg_lo_q;
          end
        end
      end else if (page >= PageChrLo && page <= PageChrHi) begin
        if (grp_hit) begin
          chr_wr = 1'b1;
          if (grp[1]) chr_val = {item_i.write_data[3:0], chr_q[slot][3:0]};
          else chr_val = {chr_q[slot][7:4], item_i.write_data[3:0]};
        end
      end else if (page == PageIrq) begin
        if (grp_hit) begin
          unique case (grp)
            2'd0: latch_d = {latch_q[7:4], item_i.write_data[3:0]};
            2'd1: begin
              enable_d = item_i.write_data[1:0];
              if (item_i.write_data[1]) count_d = latch_q;
            end
            2'd2: latch_d = {item_i.write_data[3:0], latch_q[3:0]};
            default: enable_d = {2{enable_q[0]}};
          endcase
        end
      end else begin
        // undecoded page, nothing changes
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_lo_q     <= '0;
      prg_mid_q    <= PrgMidReset;
      prg_hi_q     <= BankW'(CountReset - 9'd2);
      swap_q       <= 1'b0;
      mirror_q     <= '0;
      latch_q      <= '0;
      count_q      <= '0;
      enable_q     <= '0;
      patch_q      <= 1'b0;
      bank_count_q <= CountReset;
      for (int i = 0; i < ChrSlots; i++) chr_q[i] <= '0;
    end else if (cfg_i.wr) begin
      if (cfg_i.idx == RegPatchMode) begin
        patch_q <= cfg_i.data[0];
      end else begin
        bank_count_q <= cfg_i.data;
        prg_hi_q     <= BankW'(cfg_i.data - 9'd2);
      end
    end else if (step_i) begin
      prg_lo_q  <= prg_lo_d;
      prg_mid_q <= prg_mid_d;
      prg_hi_q  <= prg_hi_d;
      swap_q    <= swap_d;
      mirror_q  <= mirror_d;
      latch_q   <= latch_d;
      count_q   <= count_d;
      enable_q  <= enable_d;
      if (chr_wr) chr_q[slot] <= chr_val;
    end
  end

  always_comb begin
    result_o.prg_bank_lo  = prg_lo_d;
    result_o.prg_bank_mid = prg_mid_d;
    result_o.prg_bank_hi  = prg_hi_d;
    result_o.mirror_mode  = mirror_d;
    result_o.chr_update   = chr_wr;
    result_o.chr_slot     = chr_wr ? slot : '0;
    result_o.chr_bank     = chr_wr ? chr_val : '0;
    result_o.irq_pulse    = pulse;
  end

  assign patch_mode_o = patch_q;
  assign bank_count_o = bank_count_q;

endmodule

/* rtl/cartridge_bank_mapper_irq_top.sv */
// cartridge_bank_mapper_irq_top: stream wrapper with request and result registers, apb port
// depends on cbm_pkg and cbm_core
// from request accept to result valid: request register, then result register
// throughput: one request per cycle, stalls only while the result register is held by tready
// the update for a request is a single pass of decode logic into the state registers
// reset: asynchronous active low; all mapper state to power-on values, both stages empty
module cartridge_bank_mapper_irq_top import cbm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // address[15:0], write_data[23:16]
  input  logic        s_axis_tuser,  // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // prg_bank_lo, prg_bank_mid, prg_bank_hi, mirror_mode, chr_update, chr_slot,
  // chr_bank, irq_pulse, zero pad
  output logic [39:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic    in_valid_q;
  item_t   in_q;
  logic    out_valid_q;
  result_t out_q;
  logic    advance;
  result_t result;
  cfg_wr_t cfg_wr;
  logic              patch_mode;
  logic [CountW-1:0] bank_count;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (advance) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q.op         <= op_e'(s_axis_tuser);
      in_q.address    <= s_axis_tdata[15:0];
      in_q.write_data <= s_axis_tdata[23:16];
    end
    if (advance) out_q <= result;
  end

  assign pready      = 1'b1;
  assign cfg_wr.wr   = psel && penable && pwrite;
  assign cfg_wr.idx  = paddr[2];
  assign cfg_wr.data = pwdata[CountW-1:0];

  always_comb begin
    unique case (paddr[2])
      RegPatchMode: prdata = {31'd0, patch_mode};
      default:      prdata = {{(32 - CountW){1'b0}}, bank_count};
    endcase
  end

  cbm_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .item_i       (in_q),
    .cfg_i        (cfg_wr),
    .result_o     (result),
    .patch_mode_o (patch_mode),
    .bank_count_o (bank_count)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_q};

`ifndef NO_ASSERTIONS
  a_no_stall_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> s_axis_tready)
    else $error("request side stalled with an empty result register");

  a_pulse_only_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && result.irq_pulse) |-> (in_q.op == OpTick))
    else $error("irq pulse raised by a cpu write");

  a_chr_only_on_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && result.chr_update) |-> (in_q.op == OpWrite))
    else $error("character slot updated by a tick");

  a_chr_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.chr_update) |-> (out_q.chr_slot == '0 && out_q.chr_bank == '0))
    else $error("character fields not cleared without an update");

  a_result_follows_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("result lost after a processed request");
`endif

endmodule
